// ===== design/assert_macros.svh =====
// Assertion helpers included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define BHRG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define BHRG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== design/bhrg_pkg.sv =====
package bhrg_pkg;

    localparam int NUM_KEYS_DEF = 5;
    localparam int FIFO_DEPTH   = 4;
    localparam int MAX_RESULTS  = 2;

    localparam logic [2:0] REG_REPORT_MODE      = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_LIMIT   = 3'd1;
    localparam logic [2:0] REG_HOLD_TICKS_KEY0  = 3'd2;
    localparam logic [2:0] REG_HOLD_TICKS_KEY1  = 3'd3;
    localparam logic [2:0] REG_HOLD_TICKS_KEY2  = 3'd4;
    localparam logic [2:0] REG_HOLD_TICKS_OTHER = 3'd5;
    localparam logic [2:0] REG_REPEAT_GAP       = 3'd6;
    localparam logic [2:0] REG_ENCODER_HOLD     = 3'd7;

    localparam logic [7:0] CODE_RELEASE    = 8'h00;
    localparam logic [7:0] CODE_KEY0       = 8'hB7;
    localparam logic [7:0] CODE_KEY1       = 8'hB6;
    localparam logic [7:0] CODE_KEY2       = 8'hCD;
    localparam logic [7:0] CODE_KEY3       = 8'hB5;
    localparam logic [7:0] CODE_KEY_OTHER  = 8'hE2;
    localparam logic [7:0] CODE_VOL_UP     = 8'hE9;
    localparam logic [7:0] CODE_VOL_DOWN   = 8'hEA;
    localparam logic [7:0] CODE_KEYBOARD   = 8'h08;

    localparam logic [14:0] REPEAT_IDLE = 15'h7FFF;

    typedef struct packed {
        logic        report_mode;
        logic [6:0]  debounce_limit;
        logic [15:0] hold_ticks_key0;
        logic [15:0] hold_ticks_key1;
        logic [15:0] hold_ticks_key2;
        logic [15:0] hold_ticks_other;
        logic [14:0] repeat_gap;
        logic [7:0]  encoder_hold;
    } t_cfg;

    typedef struct packed {
        logic        enc_valid;
        logic        armed;
        logic [6:0]  debounce_count;
        logic        autorepeat_on;
        logic [14:0] repeat_countdown;
        logic [15:0] hold_count;
        logic [15:0] hold_target;
        logic [15:0] encoder_last;
        logic [7:0]  encoder_phase;
        logic        indicator;
    } t_state;

    typedef struct packed {
        logic [7:0] report_code;
        logic       led_on;
        logic       last_of_tick;
    } t_result;

endpackage

// ===== design/bhrg_step.sv =====
module bhrg_step #(
    parameter int NUM_KEYS = bhrg_pkg::NUM_KEYS_DEF
) (
    input  bhrg_pkg::t_state    i_state,
    input  bhrg_pkg::t_cfg      i_cfg,
    input  logic [NUM_KEYS-1:0] i_key_levels,
    input  logic                i_key_edge,
    input  logic [15:0]         i_encoder_count,
    output bhrg_pkg::t_state    o_state,
    output logic [1:0]          o_res_count,
    output bhrg_pkg::t_result   o_res0,
    output bhrg_pkg::t_result   o_res1
);
    import bhrg_pkg::*;

    always_comb begin
        t_state              s;
        logic [NUM_KEYS-1:0] down;
        logic [1:0]          n;
        logic [7:0]          code;
        logic [15:0]         diff;
        logic [14:0]         next_cd;
        logic                do_emit;

        s       = i_state;
        down    = ~i_key_levels;
        n       = 2'd0;
        o_res0  = '0;
        o_res1  = '0;
        code    = CODE_RELEASE;
        diff    = '0;
        next_cd = '0;

        if (!s.enc_valid) begin
            s.encoder_last = i_encoder_count;
            s.enc_valid    = 1'b1;
        end
        if (i_key_edge) begin
            s.armed = 1'b1;
        end

        // Key handling can give at most one report, always into the first slot.
        do_emit = 1'b0;
        if (s.armed) begin
            if (down != '0) begin
                if (s.debounce_count == i_cfg.debounce_limit) begin
                    s.debounce_count = s.debounce_count + 7'd1;
                    s.indicator      = 1'b1;
                    do_emit          = 1'b1;
                    if (!i_cfg.report_mode) begin
                        priority if (down[0]) code = CODE_KEY0;
                        else if (down[1])     code = CODE_KEY1;
                        else if (down[2])     code = CODE_KEY2;
                        else if (down[3])     code = CODE_KEY3;
                        else                  code = CODE_KEY_OTHER;
                    end else begin
                        s.hold_count = 16'd1;
                        code         = CODE_KEYBOARD;
                        priority if (down[0]) begin
                            s.hold_target   = i_cfg.hold_ticks_key0;
                            s.autorepeat_on = ~s.autorepeat_on;
                        end else if (down[1]) begin
                            s.hold_target = i_cfg.hold_ticks_key1;
                        end else if (down[2]) begin
                            s.hold_target = i_cfg.hold_ticks_key2;
                        end else begin
                            s.hold_target = i_cfg.hold_ticks_other;
                        end
                    end
                end else if (s.debounce_count < i_cfg.debounce_limit) begin
                    s.debounce_count = s.debounce_count + 7'd1;
                end
            end else begin
                s.armed          = 1'b0;
                s.debounce_count = '0;
                if (!i_cfg.report_mode) begin
                    s.indicator = 1'b0;
                    do_emit     = 1'b1;
                    code        = CODE_RELEASE;
                end
            end
        end
        if (do_emit) begin
            o_res0.report_code = code;
            o_res0.led_on      = s.indicator;
            n                  = 2'd1;
        end

        // Second stage of the tick: encoder or hold and autorepeat.
        do_emit = 1'b0;
        code    = CODE_RELEASE;
        if (!i_cfg.report_mode) begin
            diff = i_encoder_count - s.encoder_last;
            if (s.encoder_phase == '0 && i_encoder_count != s.encoder_last) begin
                s.encoder_last  = i_encoder_count;
                s.encoder_phase = 8'd1;
                code            = diff[15] ? CODE_VOL_DOWN : CODE_VOL_UP;
                do_emit         = 1'b1;
            end else if (s.encoder_phase != '0 && s.encoder_phase == i_cfg.encoder_hold) begin
                s.encoder_phase = '0;
                s.encoder_last  = i_encoder_count;
                do_emit         = 1'b1;
            end else if (s.encoder_phase != '0) begin
                s.encoder_phase = s.encoder_phase + 8'd1;
            end
            if (do_emit) begin
                if (n == 2'd0) begin
                    o_res0.report_code = code;
                    o_res0.led_on      = s.indicator;
                end else begin
                    o_res1.report_code = code;
                    o_res1.led_on      = s.indicator;
                end
                n = n + 2'd1;
            end
        end else begin
            if (s.hold_count != '0) begin
                s.hold_count = s.hold_count + 16'd1;
                if (s.hold_count == s.hold_target) begin
                    s.hold_count       = '0;
                    s.indicator        = 1'b0;
                    s.repeat_countdown = i_cfg.repeat_gap;
                    if (n == 2'd0) begin
                        o_res0.report_code = CODE_RELEASE;
                        o_res0.led_on      = s.indicator;
                    end else begin
                        o_res1.report_code = CODE_RELEASE;
                        o_res1.led_on      = s.indicator;
                    end
                    n = n + 2'd1;
                end
            end
            if (s.autorepeat_on) begin
                next_cd = s.repeat_countdown - 15'd1;
                if (next_cd == '0) begin
                    if (n < 2'(MAX_RESULTS)) begin
                        s.hold_count       = 16'd1;
                        s.repeat_countdown = REPEAT_IDLE;
                        s.indicator        = 1'b1;
                        if (n == 2'd0) begin
                            o_res0.report_code = CODE_KEYBOARD;
                            o_res0.led_on      = s.indicator;
                        end else begin
                            o_res1.report_code = CODE_KEYBOARD;
                            o_res1.led_on      = s.indicator;
                        end
                        n = n + 2'd1;
                    end else begin
                        s.repeat_countdown = 15'd1;
                    end
                end else begin
                    s.repeat_countdown = next_cd;
                end
            end
        end

        o_res0.last_of_tick = (n == 2'd1);
        o_res1.last_of_tick = 1'b1;
        o_res_count         = n;
        o_state             = s;
    end

endmodule

// ===== design/button_encoder_hid_report_gen.sv =====
// Channel  | Direction | Handshake              | Beat carries
// ---------+-----------+------------------------+-----------------------------------------
// input    | in        | i_valid / o_ready      | key levels, key edge, encoder count
// result   | out       | o_valid / i_ready      | report code, LED state, last-of-tick flag
// config   | in        | i_cfg_valid / o_cfg_ready | register index, write data
//
// A tick beat is captured in an input register and processed once
// the four-entry result queue has room for two more beats.
// One tick per cycle is sustained while each tick gives at most one result and i_ready stays high;
// the result queue drains one beat per cycle at most, so ticks that give two results limit the rate there.
// A stalled result side fills the queue and then holds o_ready low.
// Synchronous active-low reset restores register defaults and empties the queue;
// config writes are taken in every cycle outside reset.
module button_encoder_hid_report_gen #(
    parameter int NUM_KEYS = bhrg_pkg::NUM_KEYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [NUM_KEYS-1:0] i_key_levels,
    input  logic                i_key_edge,
    input  logic [15:0]         i_encoder_count,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_report_code,
    output logic                o_led_on,
    output logic                o_last_of_tick,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import bhrg_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cfg                r_cfg;
    t_state              r_state;
    t_state              w_state_nx;
    logic                r_in_valid;
    logic [NUM_KEYS-1:0] r_key_levels;
    logic                r_key_edge;
    logic [15:0]         r_encoder_count;

    t_result             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    logic [1:0]          w_res_count;
    t_result             w_res0;
    t_result             w_res1;
    logic                w_pop;
    logic                w_go;
    logic [CNT_W-1:0]    w_level;
    logic [CNT_W-1:0]    w_push;

    bhrg_step #(
        .NUM_KEYS(NUM_KEYS)
    ) u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_key_levels   (r_key_levels),
        .i_key_edge     (r_key_edge),
        .i_encoder_count(r_encoder_count),
        .o_state        (w_state_nx),
        .o_res_count    (w_res_count),
        .o_res0         (w_res0),
        .o_res1         (w_res1)
    );

    assign o_valid        = (r_count != '0);
    assign o_report_code  = r_fifo[r_rd_ptr].report_code;
    assign o_led_on       = r_fifo[r_rd_ptr].led_on;
    assign o_last_of_tick = r_fifo[r_rd_ptr].last_of_tick;
    assign o_cfg_ready    = 1'b1;

    assign w_pop   = o_valid && i_ready;
    assign w_level = r_count - CNT_W'(w_pop);
    assign w_go    = r_in_valid && (w_level <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign w_push  = w_go ? CNT_W'(w_res_count) : '0;
    assign o_ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.report_mode      <= 1'b0;
            r_cfg.debounce_limit   <= 7'd16;
            r_cfg.hold_ticks_key0  <= 16'd10;
            r_cfg.hold_ticks_key1  <= 16'd56;
            r_cfg.hold_ticks_key2  <= 16'd91;
            r_cfg.hold_ticks_other <= 16'd142;
            r_cfg.repeat_gap       <= 15'd160;
            r_cfg.encoder_hold     <= 8'd7;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_REPORT_MODE:      r_cfg.report_mode      <= i_cfg_data[0];
                REG_DEBOUNCE_LIMIT:   r_cfg.debounce_limit   <= i_cfg_data[6:0];
                REG_HOLD_TICKS_KEY0:  r_cfg.hold_ticks_key0  <= i_cfg_data;
                REG_HOLD_TICKS_KEY1:  r_cfg.hold_ticks_key1  <= i_cfg_data;
                REG_HOLD_TICKS_KEY2:  r_cfg.hold_ticks_key2  <= i_cfg_data;
                REG_HOLD_TICKS_OTHER: r_cfg.hold_ticks_other <= i_cfg_data;
                REG_REPEAT_GAP:       r_cfg.repeat_gap       <= i_cfg_data[14:0];
                REG_ENCODER_HOLD:     r_cfg.encoder_hold     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_in_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (w_go) begin
                r_state <= w_state_nx;
            end
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(w_push);
            r_rd_ptr <= r_rd_ptr + PTR_W'(w_pop);
            r_count  <= w_level + w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_key_levels    <= i_key_levels;
            r_key_edge      <= i_key_edge;
            r_encoder_count <= i_encoder_count;
        end
        if (w_push != '0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_push == CNT_W'(MAX_RESULTS)) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= w_res1;
        end
    end

    `include "assert_macros.svh"

    `BHRG_ASSERT(a_count_bound, r_count <= CNT_W'(FIFO_DEPTH), "result queue overfilled")
    `BHRG_ASSERT(a_pair_whole, (w_pop && !o_last_of_tick) |=> o_valid, "tick results split")
    `BHRG_ASSERT(a_room_on_push, (w_push != '0) |-> (w_level + w_push <= CNT_W'(FIFO_DEPTH)),
        "push without room")
    `BHRG_ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> (r_count == '0), "queue not cleared")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bhrg_pkg::*;

    localparam int NUM_PHASES      = 16;
    localparam int NUM_DIRECTED    = 30;
    localparam int BASE_QUOTA      = 95;
    localparam int LONG_QUOTA      = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        logic [4:0]  levels;
        logic        key_edge;
        logic [15:0] enc;
        logic        typed;
        logic [1:0]  n_rep;
        logic [7:0]  code0;
        logic        led0;
        logic [7:0]  code1;
        logic        led1;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_key_levels = 5'h1F;
    logic        i_key_edge = 1'b0;
    logic [15:0] i_encoder_count = 16'h0000;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_report_code;
    logic        o_led_on;
    logic        o_last_of_tick;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_REPORT_MODE;
    logic [15:0] i_cfg_data = 16'h0000;

    t_cfg        hid_regs;
    t_state      hid_state;
    t_result     pending_reports[$];
    t_step_row   directed_steps[0:NUM_DIRECTED-1];

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          stall_pct = 0;
    int          ticks_left = 0;
    int          tick_report_count = 0;
    logic        hold_off_go = 1'b0;
    logic        hold_off_seen = 1'b0;
    int          hold_off_left = 0;
    logic [15:0] enc_pos = 16'h0000;
    bit          long_press_next = 1'b0;

    button_encoder_hid_report_gen u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_key_levels   (i_key_levels),
        .i_key_edge     (i_key_edge),
        .i_encoder_count(i_encoder_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_report_code  (o_report_code),
        .o_led_on       (o_led_on),
        .o_last_of_tick (o_last_of_tick),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The long hold-off counts in this process only; the stimulus merely requests it.
    always @(posedge i_clk) begin
        if (hold_off_go != hold_off_seen) begin
            hold_off_seen <= hold_off_go;
            hold_off_left <= HOLD_OFF_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report beat code=%h led=%b last=%b", $time,
                         o_report_code, o_led_on, o_last_of_tick);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_report_code != want.report_code) begin
                    $display("%0t: report_code expected %h actual %h", $time,
                             want.report_code, o_report_code);
                    mismatch_count++;
                end
                if (o_led_on != want.led_on) begin
                    $display("%0t: led_on expected %b actual %b", $time,
                             want.led_on, o_led_on);
                    mismatch_count++;
                end
                if (o_last_of_tick != want.last_of_tick) begin
                    $display("%0t: last_of_tick expected %b actual %b", $time,
                             want.last_of_tick, o_last_of_tick);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void queue_report(input logic [7:0] code);
        t_result r;
        r.report_code = code;
        r.led_on = hid_state.indicator;
        r.last_of_tick = 1'b0;
        pending_reports.push_back(r);
    endfunction

    function automatic int compute_tick_reports(input logic [4:0] levels, input logic kedge,
                                                input logic [15:0] enc);
        logic [4:0]  held;
        logic [15:0] diff;
        logic [14:0] countdown_next;
        logic [7:0]  code;
        t_result     r;
        int          n;
        held = ~levels;
        n = 0;
        if (!hid_state.enc_valid) begin
            hid_state.encoder_last = enc;
            hid_state.enc_valid = 1'b1;
        end
        if (kedge) begin
            hid_state.armed = 1'b1;
        end
        if (hid_state.armed) begin
            if (held != 5'd0) begin
                if (hid_state.debounce_count == hid_regs.debounce_limit) begin
                    hid_state.debounce_count = hid_state.debounce_count + 7'd1;
                    hid_state.indicator = 1'b1;
                    if (hid_regs.report_mode == 1'b0) begin
                        if (held[0]) code = CODE_KEY0;
                        else if (held[1]) code = CODE_KEY1;
                        else if (held[2]) code = CODE_KEY2;
                        else if (held[3]) code = CODE_KEY3;
                        else code = CODE_KEY_OTHER;
                        queue_report(code);
                        n++;
                    end else begin
                        hid_state.hold_count = 16'd1;
                        if (held[0]) begin
                            hid_state.hold_target = hid_regs.hold_ticks_key0;
                            hid_state.autorepeat_on = ~hid_state.autorepeat_on;
                        end else if (held[1]) begin
                            hid_state.hold_target = hid_regs.hold_ticks_key1;
                        end else if (held[2]) begin
                            hid_state.hold_target = hid_regs.hold_ticks_key2;
                        end else begin
                            hid_state.hold_target = hid_regs.hold_ticks_other;
                        end
                        queue_report(CODE_KEYBOARD);
                        n++;
                    end
                end else if (hid_state.debounce_count < hid_regs.debounce_limit) begin
                    hid_state.debounce_count = hid_state.debounce_count + 7'd1;
                end
            end else begin
                hid_state.armed = 1'b0;
                hid_state.debounce_count = 7'd0;
                if (hid_regs.report_mode == 1'b0) begin
                    hid_state.indicator = 1'b0;
                    queue_report(CODE_RELEASE);
                    n++;
                end
            end
        end
        if (hid_regs.report_mode == 1'b0) begin
            if (hid_state.encoder_phase == 8'd0 && enc != hid_state.encoder_last) begin
                diff = enc - hid_state.encoder_last;
                hid_state.encoder_last = enc;
                hid_state.encoder_phase = 8'd1;
                queue_report((diff != 16'd0 && !diff[15]) ? CODE_VOL_UP : CODE_VOL_DOWN);
                n++;
            end else if (hid_state.encoder_phase != 8'd0 &&
                         hid_state.encoder_phase == hid_regs.encoder_hold) begin
                hid_state.encoder_phase = 8'd0;
                hid_state.encoder_last = enc;
                queue_report(CODE_RELEASE);
                n++;
            end else if (hid_state.encoder_phase != 8'd0) begin
                hid_state.encoder_phase = hid_state.encoder_phase + 8'd1;
            end
        end else begin
            if (hid_state.hold_count != 16'd0) begin
                hid_state.hold_count = hid_state.hold_count + 16'd1;
                if (hid_state.hold_count == hid_state.hold_target) begin
                    hid_state.hold_count = 16'd0;
                    hid_state.indicator = 1'b0;
                    hid_state.repeat_countdown = hid_regs.repeat_gap;
                    queue_report(CODE_RELEASE);
                    n++;
                end
            end
            if (hid_state.autorepeat_on) begin
                countdown_next = hid_state.repeat_countdown - 15'd1;
                if (countdown_next == 15'd0) begin
                    if (n < MAX_RESULTS) begin
                        hid_state.hold_count = 16'd1;
                        hid_state.repeat_countdown = REPEAT_IDLE;
                        hid_state.indicator = 1'b1;
                        queue_report(CODE_KEYBOARD);
                        n++;
                    end else begin
                        hid_state.repeat_countdown = 15'd1;
                    end
                end else begin
                    hid_state.repeat_countdown = countdown_next;
                end
            end
        end
        if (n > 0) begin
            r = pending_reports.pop_back();
            r.last_of_tick = 1'b1;
            pending_reports.push_back(r);
        end
        return n;
    endfunction

    function automatic t_step_row cfg_row(input logic [2:0] idx, input logic [15:0] val);
        t_step_row s;
        s = '0;
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic t_step_row tick_row(input logic [4:0] lv, input logic ke,
                                           input logic [15:0] en);
        t_step_row s;
        s = '0;
        s.levels = lv;
        s.key_edge = ke;
        s.enc = en;
        return s;
    endfunction

    function automatic t_step_row tick_exp(input logic [4:0] lv, input logic ke,
                                           input logic [15:0] en, input logic [1:0] n,
                                           input logic [7:0] c0, input logic l0,
                                           input logic [7:0] c1, input logic l1);
        t_step_row s;
        s = tick_row(lv, ke, en);
        s.typed = 1'b1;
        s.n_rep = n;
        s.code0 = c0;
        s.led0 = l0;
        s.code1 = c1;
        s.led1 = l1;
        return s;
    endfunction

    function automatic logic [15:0] next_enc();
        int r;
        r = $urandom_range(99);
        if (r < 15) enc_pos = enc_pos + 16'($urandom_range(1, 3));
        else if (r < 30) enc_pos = enc_pos - 16'($urandom_range(1, 3));
        else if (r < 37) enc_pos = 16'($urandom);
        else if (r < 40) enc_pos = enc_pos + 16'h8000;
        return enc_pos;
    endfunction

    function automatic logic [15:0] pick_hold();
        return ($urandom_range(7) == 0) ? 16'd2 : 16'($urandom_range(3, 40));
    endfunction

    task automatic send_tick(input logic [4:0] levels, input logic kedge,
                             input logic [15:0] enc);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_key_levels <= levels;
        i_key_edge <= kedge;
        i_encoder_count <= enc;
        do @(posedge i_clk); while (!o_ready);
        tick_report_count = compute_tick_reports(levels, kedge, enc);
        ticks_left--;
    endtask

    task automatic drain_reports();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic settle();
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_REPORT_MODE:      hid_regs.report_mode = data[0];
            REG_DEBOUNCE_LIMIT:   hid_regs.debounce_limit = data[6:0];
            REG_HOLD_TICKS_KEY0:  hid_regs.hold_ticks_key0 = data;
            REG_HOLD_TICKS_KEY1:  hid_regs.hold_ticks_key1 = data;
            REG_HOLD_TICKS_KEY2:  hid_regs.hold_ticks_key2 = data;
            REG_HOLD_TICKS_OTHER: hid_regs.hold_ticks_other = data;
            REG_REPEAT_GAP:       hid_regs.repeat_gap = data[14:0];
            REG_ENCODER_HOLD:     hid_regs.encoder_hold = data[7:0];
            default: ;
        endcase
    endtask

    task automatic program_phase(input int p);
        logic        mode;
        logic [6:0]  dl;
        logic [15:0] h0, h1, h2, ho;
        logic [14:0] gap;
        logic [7:0]  eh;
        mode = 1'((p / 2) % 2);
        case (p)
            4, 7: begin
                dl = 7'd0;
                h0 = 16'd0;
                h1 = 16'd1;
                h2 = 16'd0;
                ho = 16'd1;
                gap = 15'd0;
                eh = 8'd0;
            end
            9, 14: begin
                dl = 7'h7F;
                h0 = 16'hFFFF;
                h1 = 16'hFFFF;
                h2 = 16'hFFFF;
                ho = 16'hFFFF;
                gap = 15'h7FFF;
                eh = 8'hFF;
            end
            default: begin
                dl = ($urandom_range(9) == 0) ? 7'd126 : 7'($urandom_range(6));
                h0 = pick_hold();
                h1 = pick_hold();
                h2 = pick_hold();
                ho = pick_hold();
                gap = ($urandom_range(9) == 0) ? 15'd1 : 15'($urandom_range(2, 30));
                eh = ($urandom_range(9) == 0) ? 8'd1 : 8'($urandom_range(2, 12));
            end
        endcase
        write_reg(REG_REPORT_MODE, {15'($urandom), mode});
        write_reg(REG_DEBOUNCE_LIMIT, {9'($urandom), dl});
        write_reg(REG_HOLD_TICKS_KEY0, h0);
        write_reg(REG_HOLD_TICKS_KEY1, h1);
        write_reg(REG_HOLD_TICKS_KEY2, h2);
        write_reg(REG_HOLD_TICKS_OTHER, ho);
        write_reg(REG_REPEAT_GAP, {1'($urandom), gap});
        write_reg(REG_ENCODER_HOLD, {8'($urandom), eh});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic play_press();
        logic [4:0] keys;
        int         hold_len;
        int         limit;
        int         r;
        int         k;
        int         gap_len;
        limit = int'(hid_regs.debounce_limit);
        keys = ($urandom_range(99) < 45) ? 5'(1 << $urandom_range(4))
                                         : 5'($urandom_range(1, 31));
        r = $urandom_range(99);
        if (long_press_next || (r >= 55 && r < 70)) hold_len = 2 * limit + $urandom_range(2, 6);
        else if (r < 55) hold_len = limit + $urandom_range(1, 5);
        else if (r < 85) hold_len = $urandom_range(0, limit);
        else hold_len = $urandom_range(1, 8);
        long_press_next = 1'b0;
        if (ticks_left > 0) begin
            send_tick(~keys, 1'b1, next_enc());
        end
        for (k = 0; k < hold_len && ticks_left > 0; k++) begin
            if ($urandom_range(99) < 10) begin
                keys = 5'($urandom_range(1, 31));
            end
            send_tick(~keys, ($urandom_range(99) < 5), next_enc());
        end
        gap_len = $urandom_range(1, 4);
        for (k = 0; k < gap_len && ticks_left > 0; k++) begin
            send_tick(5'h1F, ($urandom_range(99) < 5), next_enc());
        end
    endtask

    initial begin
        int  i;
        int  p;
        int  quota;
        bit  prev_cfg;
        bit  paused;
        int  noise_len;
        int  k;
        t_step_row row;
        t_result   typed_rep;

        hid_regs = '{1'b0, 7'd16, 16'd10, 16'd56, 16'd91, 16'd142, 15'd160, 8'd7};
        hid_state = '0;

        directed_steps = '{
            cfg_row(REG_DEBOUNCE_LIMIT, 16'd0),
            cfg_row(REG_ENCODER_HOLD, 16'd1),
            tick_exp(5'h1F, 1'b0, 16'h0000, 2'd0, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h00, 1'b1, 16'h0000, 2'd1, CODE_KEY0, 1'b1, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h0000, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h1D, 1'b1, 16'h0000, 2'd1, CODE_KEY1, 1'b1, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h0000, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h1B, 1'b1, 16'h0000, 2'd1, CODE_KEY2, 1'b1, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h0000, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h17, 1'b1, 16'h0000, 2'd1, CODE_KEY3, 1'b1, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h0000, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h0F, 1'b1, 16'h0000, 2'd1, CODE_KEY_OTHER, 1'b1, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'hFFFF, 2'd2, CODE_RELEASE, 1'b0, CODE_VOL_DOWN, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'hFFFF, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h7FFF, 2'd1, CODE_VOL_DOWN, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h7FFF, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h8000, 2'd1, CODE_VOL_UP, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h8000, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            tick_exp(5'h1E, 1'b1, 16'h8001, 2'd2, CODE_KEY0, 1'b1, CODE_VOL_UP, 1'b1),
            tick_exp(5'h1E, 1'b0, 16'h8001, 2'd1, CODE_RELEASE, 1'b1, CODE_RELEASE, 1'b0),
            tick_exp(5'h1F, 1'b0, 16'h8001, 2'd1, CODE_RELEASE, 1'b0, CODE_RELEASE, 1'b0),
            cfg_row(REG_REPORT_MODE, 16'd1),
            cfg_row(REG_HOLD_TICKS_KEY0, 16'd2),
            cfg_row(REG_REPEAT_GAP, 16'd1),
            tick_row(5'h1E, 1'b1, 16'h8001),
            tick_row(5'h1E, 1'b0, 16'h8001),
            tick_row(5'h1E, 1'b0, 16'h8001),
            tick_row(5'h1F, 1'b0, 16'h8001),
            tick_row(5'h1E, 1'b1, 16'h8001),
            tick_row(5'h1F, 1'b0, 16'h8001)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        for (i = 0; i < NUM_DIRECTED; i++) begin
            row = directed_steps[i];
            if (row.is_cfg) begin
                if (!prev_cfg) begin
                    settle();
                end
                write_reg(row.reg_idx, row.reg_val);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) begin
                    i_cfg_valid <= 1'b0;
                end
                prev_cfg = 1'b0;
                send_tick(row.levels, row.key_edge, row.enc);
                if (row.typed) begin
                    repeat (tick_report_count) void'(pending_reports.pop_back());
                    if (row.n_rep != 2'd0) begin
                        typed_rep = '{row.code0, row.led0, (row.n_rep == 2'd1)};
                        pending_reports.push_back(typed_rep);
                    end
                    if (row.n_rep == 2'd2) begin
                        typed_rep = '{row.code1, row.led1, 1'b1};
                        pending_reports.push_back(typed_rep);
                    end
                end
            end
        end
        enc_pos = 16'h8001;

        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin tx_idle_pct = 0;  stall_pct <= 0;  end
                1: begin tx_idle_pct = 61; stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  stall_pct <= 61; end
                default: begin tx_idle_pct = 13; stall_pct <= 13; end
            endcase
            program_phase(p);
            quota = (hid_regs.debounce_limit >= 7'd126) ? LONG_QUOTA : BASE_QUOTA;
            ticks_left = quota;
            long_press_next = 1'b1;
            paused = 1'b0;
            if (p == 0) begin
                hold_off_go <= ~hold_off_go;
            end
            while (ticks_left > 0) begin
                if (p == 2 && !paused && ticks_left < quota / 2) begin
                    drain_reports();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 85) begin
                    play_press();
                end else begin
                    noise_len = $urandom_range(1, 4);
                    for (k = 0; k < noise_len && ticks_left > 0; k++) begin
                        enc_pos = 16'($urandom);
                        send_tick(5'($urandom), 1'($urandom), enc_pos);
                    end
                end
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
